@@ rtl/khfw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khfw_pkg: shared types and constants of the keyed hash block
// Lane and item records that travel along the round chain, the per-cell
// mixing controls, the hash constants and the register indexes.
// ----------------------------------------------------------------------------
package khfw_pkg;

   localparam int WORD_W     = 64;
   localparam int NUM_ROUNDS = 10;  // two per message block (up to three), four final
   localparam int CSR_IDX_W  = 8;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 8'd1;

   // initialization constants of the four lanes
   localparam logic [WORD_W-1:0] INIT_V0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] INIT_V1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] INIT_V2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] INIT_V3 = 64'h7465646279746573;

   // final block: length in bytes in bits 63..56
   localparam logic [WORD_W-1:0] LEN_BLOCK_ONE = 64'h0800_0000_0000_0000;
   localparam logic [WORD_W-1:0] LEN_BLOCK_TWO = 64'h1000_0000_0000_0000;
   localparam logic [WORD_W-1:0] FINAL_MARK    = 64'h0000_0000_0000_00ff;

   typedef struct packed {
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
   } lanes_type;

   // one item in flight: the message and the running lanes
   typedef struct packed {
      logic              mode;
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      lanes_type         lanes;
   } item_type;

   // what one cell folds in ahead of its round
   typedef struct packed {
      logic              bypass;
      logic [WORD_W-1:0] x0;
      logic [WORD_W-1:0] x2;
      logic [WORD_W-1:0] x3;
   } mix_type;

endpackage : khfw_pkg
`default_nettype wire

@@ rtl/khfw_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khfw_cell: one round cell of the hash chain
// Folds the mix words into the incoming lanes, runs one SipRound (unless
// told to pass through) and holds the item until the next cell takes it.
// ----------------------------------------------------------------------------
module khfw_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   input  wire khfw_pkg::item_type up_item,
   input  wire khfw_pkg::mix_type  up_mix,
   output logic                    up_ready,
   output logic                    dn_valid,
   output khfw_pkg::item_type      dn_item,
   input  wire logic               dn_ready
);
   import khfw_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   item_type  item_ff;
   item_type  item_in;
   lanes_type mixed;

   function automatic lanes_type sip_round(input lanes_type s_in);
      lanes_type s;
      s = s_in;
      s.v0 = s.v0 + s.v1;
      s.v1 = {s.v1[50:0], s.v1[63:51]};
      s.v1 = s.v1 ^ s.v0;
      s.v0 = {s.v0[31:0], s.v0[63:32]};
      s.v2 = s.v2 + s.v3;
      s.v3 = {s.v3[47:0], s.v3[63:48]};
      s.v3 = s.v3 ^ s.v2;
      s.v0 = s.v0 + s.v3;
      s.v3 = {s.v3[42:0], s.v3[63:43]};
      s.v3 = s.v3 ^ s.v0;
      s.v2 = s.v2 + s.v1;
      s.v1 = {s.v1[46:0], s.v1[63:47]};
      s.v1 = s.v1 ^ s.v2;
      s.v2 = {s.v2[31:0], s.v2[63:32]};
      return s;
   endfunction

   // free slot or the held item moves on this cycle
   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

   // fold in the mix words, then one round unless bypass is set
   always_comb begin
      mixed    = up_item.lanes;
      mixed.v0 = up_item.lanes.v0 ^ up_mix.x0;
      mixed.v2 = up_item.lanes.v2 ^ up_mix.x2;
      mixed.v3 = up_item.lanes.v3 ^ up_mix.x3;
      item_in  = up_item;
      if (up_mix.bypass) begin
         item_in.lanes = mixed;
      end else begin
         item_in.lanes = sip_round(mixed);
      end
   end

   // take a new item whenever the slot frees up
   always_comb begin
      if (up_ready) begin
         valid_in = up_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         item_ff <= item_in;
      end
   end

endmodule : khfw_cell
`default_nettype wire

@@ rtl/keyed_hash_fixed_words.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_hash_fixed_words: SipHash-2-4 of a one- or two-word message
// Ten round cells in a row, then an output register.
// ----------------------------------------------------------------------------
// The block takes one item per cycle when nothing stalls and returns its
// 64-bit hash from the output register: each of the ten round cells runs
// one SipRound, and the output register folds the lanes into the hash.
// Two-word items use all ten rounds; one-word items pass the first two
// cells without a round, so every item sees the same latency and results
// leave in order. Each cell holds one item and frees up as soon as its
// successor can take it, so gaps close up while the result side stalls.
// Write the key registers only while no item is in flight.
module keyed_hash_fixed_words (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_mode,
   input  wire logic [khfw_pkg::WORD_W-1:0]      req_first_word,
   input  wire logic [khfw_pkg::WORD_W-1:0]      req_second_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [khfw_pkg::WORD_W-1:0]           rsp_hash_value,
   input  wire logic                             csr_write_enable,
   input  wire logic [khfw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [khfw_pkg::WORD_W-1:0]      csr_write_data
);
   import khfw_pkg::*;

   localparam int OCC_W = $clog2(NUM_ROUNDS + 2);

   logic [WORD_W-1:0] key_low_ff;
   logic [WORD_W-1:0] key_high_ff;

   logic [NUM_ROUNDS:0] chain_valid;
   logic [NUM_ROUNDS:0] chain_ready;
   item_type            chain_item [NUM_ROUNDS+1];
   mix_type             chain_mix  [NUM_ROUNDS];

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_hash_ff;
   logic              out_ready;

   logic              in_xfer;
   logic              out_xfer;
   logic [OCC_W-1:0]  occupancy;

   // mix words folded in ahead of the round of each cell
   function automatic mix_type stage_mix(input int stage, input item_type it);
      mix_type           m;
      logic [WORD_W-1:0] len_block;
      logic [WORD_W-1:0] mid_word;
      m         = '0;
      len_block = it.mode ? LEN_BLOCK_TWO : LEN_BLOCK_ONE;
      mid_word  = it.mode ? it.word_b : it.word_a;
      unique case (stage)
         0: begin
            m.bypass = !it.mode;
            m.x3     = it.mode ? it.word_a : '0;
         end
         1: begin
            m.bypass = !it.mode;
         end
         2: begin
            m.x0 = it.mode ? it.word_a : '0;
            m.x3 = mid_word;
         end
         4: begin
            m.x0 = mid_word;
            m.x3 = len_block;
         end
         6: begin
            m.x0 = len_block;
            m.x2 = FINAL_MARK;
         end
         default: begin
            m = '0;
         end
      endcase
      return m;
   endfunction

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_KEY_LOW) begin
            key_low_ff <= csr_write_data;
         end
         if (csr_index == CSR_KEY_HIGH) begin
            key_high_ff <= csr_write_data;
         end
      end
   end

   // load the keyed lanes at the head of the chain
   always_comb begin
      chain_item[0].mode     = req_mode;
      chain_item[0].word_a   = req_first_word;
      chain_item[0].word_b   = req_second_word;
      chain_item[0].lanes.v0 = INIT_V0 ^ key_low_ff;
      chain_item[0].lanes.v1 = INIT_V1 ^ key_high_ff;
      chain_item[0].lanes.v2 = INIT_V2 ^ key_low_ff;
      chain_item[0].lanes.v3 = INIT_V3 ^ key_high_ff;
   end

   assign chain_valid[0] = req_valid;
   assign req_stall      = !chain_ready[0];

   // round cells
   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
      assign chain_mix[i] = stage_mix(i, chain_item[i]);

      khfw_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_item  (chain_item[i]),
         .up_mix   (chain_mix[i]),
         .up_ready (chain_ready[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_item  (chain_item[i+1]),
         .dn_ready (chain_ready[i+1])
      );
   end

   // output register: fold the lanes into the hash
   assign out_ready               = !rsp_valid_ff || !rsp_stall;
   assign chain_ready[NUM_ROUNDS] = out_ready;

   always_comb begin
      if (out_ready) begin
         rsp_valid_in = chain_valid[NUM_ROUNDS];
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_valid[NUM_ROUNDS] && out_ready) begin
         rsp_hash_ff <= chain_item[NUM_ROUNDS].lanes.v0 ^ chain_item[NUM_ROUNDS].lanes.v1
                      ^ chain_item[NUM_ROUNDS].lanes.v2 ^ chain_item[NUM_ROUNDS].lanes.v3;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // transfer bookkeeping for the checks below
   assign in_xfer   = req_valid && !req_stall;
   assign out_xfer  = rsp_valid && !rsp_stall;
   assign occupancy = OCC_W'($countones(chain_valid[NUM_ROUNDS:1])) + OCC_W'(rsp_valid_ff);

`ifndef SYNTHESIS
   // items in flight change only by transfers at the two ends
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((occupancy + OCC_W'($past(out_xfer)))
                         == ($past(occupancy) + OCC_W'($past(in_xfer)))))
      else $error("item count in the chain does not match transfers");

   // a finished item fills an empty output register at once
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (chain_valid[NUM_ROUNDS] && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished item not moved to the output register");

   // input stalls only while the first cell is occupied
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> chain_valid[1])
      else $error("input stalled with the first cell empty");
`endif

endmodule : keyed_hash_fixed_words
`default_nettype wire
